### src/assert_macros.svh
// Assertion macros shared by the RTL of this block.
// Needs signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/nlp_pkg.sv
// Shared types of the next-permutation block.
// No dependencies.
package nlp_pkg;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PV_RD,
		ST_PV_CMP,
		ST_HI_RD,
		ST_HI_CMP,
		ST_SW_PVT,
		ST_SW_HI,
		ST_RV_RD,
		ST_RV_WLO,
		ST_RV_WHI,
		ST_OUT_RD,
		ST_OUT_PUT
	} nlp_state_t;

endpackage

### src/nlp_mem.sv
// Element store: one write port, two read ports with registered read data.
// No package dependencies.
module nlp_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next enabled read
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### src/next_lexicographic_permutation.sv
// Next lexicographic permutation: top level.
// Uses nlp_pkg (state type), nlp_mem (element store) and assert_macros.svh.
//
// Load a sequence one element per input transaction, the last one marked by
// elem_last. Up to MAX_ELEMS elements are kept, later ones are dropped and the
// run reports overflowed. After the closing transaction in_ready stays low
// while the block finds the rightmost ascent (pivot), swaps it with the
// rightmost larger element, reverses the suffix and then emits the sequence
// one element per output transaction with has_next set if a new permutation
// was formed. All element compares share one signed comparator and all
// updates share the single store write port, so the pivot scan, the search
// for the larger element, the swap, the reversal and the emission run in
// turn. A sequence of fewer than two elements goes straight to emission. A
// result waiting in the output register does not block loading of the next
// sequence.
`include "assert_macros.svh"

module next_lexicographic_permutation #(
	parameter int MAX_ELEMS  = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [ELEM_WIDTH-1:0] elem_value,
	input  logic                         elem_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ELEM_WIDTH-1:0] out_value,
	output logic                         out_last,
	output logic                         has_next,
	output logic                         overflowed
);

	import nlp_pkg::*;

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ELEMS);

	nlp_state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          nxt_q;
	logic [AW-1:0] pvt_q, hi_q, lo_q, k_q;
	logic [ELEM_WIDTH-1:0] pv_val_q, hv_q;

	logic                  out_valid_q;
	logic [ELEM_WIDTH-1:0] out_value_q;
	logic                  out_last_q, has_next_q, overflowed_q;

	// store ports
	logic                  mem_we, re_a, re_b;
	logic [AW-1:0]         waddr, raddr_a, raddr_b;
	logic [ELEM_WIDTH-1:0] wdata, rd_a, rd_b;

	// shared comparator
	logic [ELEM_WIDTH-1:0] cmp_a, cmp_b;
	logic                  cmp_lt;

	logic          in_acc, out_free, room, k_last, out_load;
	logic [CW-1:0] n_new;
	logic [AW-1:0] last_idx;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign room     = cnt_q != FULL_CNT;
	assign n_new    = room ? cnt_q + CW'(1) : cnt_q;
	// count is at least one once the run is closed
	assign last_idx = AW'(cnt_q - CW'(1));
	assign k_last   = k_q == last_idx;
	assign out_load = (state_q == ST_OUT_PUT) && out_free;
	assign cmp_lt   = $signed(cmp_a) < $signed(cmp_b);

	nlp_mem #(
		.DEPTH(MAX_ELEMS),
		.WIDTH(ELEM_WIDTH)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re_a   (re_a),
		.raddr_a(raddr_a),
		.rdata_a(rd_a),
		.re_b   (re_b),
		.raddr_b(raddr_b),
		.rdata_b(rd_b)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && elem_last) begin
					state_d = (n_new >= CW'(2)) ? ST_PV_RD : ST_OUT_RD;
				end
			end
			ST_PV_RD:  state_d = ST_PV_CMP;
			ST_PV_CMP: begin
				if (cmp_lt) begin
					state_d = ST_HI_RD;
				end else if (pvt_q == '0) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_PV_RD;
				end
			end
			ST_HI_RD:  state_d = ST_HI_CMP;
			ST_HI_CMP: state_d = cmp_lt ? ST_SW_PVT : ST_HI_RD;
			ST_SW_PVT: state_d = ST_SW_HI;
			ST_SW_HI:  state_d = ST_RV_RD;
			ST_RV_RD:  state_d = (lo_q < hi_q) ? ST_RV_WLO : ST_OUT_RD;
			ST_RV_WLO: state_d = ST_RV_WHI;
			ST_RV_WHI: state_d = ST_RV_RD;
			ST_OUT_RD: state_d = ST_OUT_PUT;
			ST_OUT_PUT: begin
				if (out_free) begin
					state_d = k_last ? ST_LOAD : ST_OUT_RD;
				end
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	// Store ports and comparator operands
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		waddr    = cnt_q[AW-1:0];
		wdata    = elem_value;
		re_a     = 1'b0;
		re_b     = 1'b0;
		raddr_a  = lo_q;
		raddr_b  = hi_q;
		cmp_a    = rd_a;
		cmp_b    = rd_b;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				mem_we   = in_acc && room;
			end
			ST_PV_RD: begin
				re_a    = 1'b1;
				re_b    = 1'b1;
				raddr_a = pvt_q;
				raddr_b = pvt_q + AW'(1);
			end
			ST_PV_CMP: begin
				cmp_a = rd_a;
				cmp_b = rd_b;
			end
			ST_HI_RD: begin
				re_a    = 1'b1;
				raddr_a = hi_q;
			end
			ST_HI_CMP: begin
				cmp_a = pv_val_q;
				cmp_b = rd_a;
			end
			ST_SW_PVT: begin
				mem_we = 1'b1;
				waddr  = pvt_q;
				wdata  = hv_q;
			end
			ST_SW_HI: begin
				mem_we = 1'b1;
				waddr  = hi_q;
				wdata  = pv_val_q;
			end
			ST_RV_RD: begin
				re_a    = 1'b1;
				re_b    = 1'b1;
				raddr_a = lo_q;
				raddr_b = hi_q;
			end
			ST_RV_WLO: begin
				mem_we = 1'b1;
				waddr  = lo_q;
				wdata  = rd_b;
			end
			ST_RV_WHI: begin
				mem_we = 1'b1;
				waddr  = hi_q;
				wdata  = rd_a;
			end
			ST_OUT_RD: begin
				re_a    = 1'b1;
				raddr_a = k_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			// drop the sequence once its last element is handed to the output
			if (out_load && k_last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Indexes, held values and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_acc && elem_last) begin
					nxt_q <= 1'b0;
					k_q   <= '0;
					pvt_q <= AW'(n_new - CW'(2));
				end
			end
			ST_PV_CMP: begin
				if (cmp_lt) begin
					pv_val_q <= rd_a;
					hi_q     <= last_idx;
					nxt_q    <= 1'b1;
				end else if (pvt_q != '0) begin
					pvt_q <= pvt_q - AW'(1);
				end
			end
			ST_HI_CMP: begin
				if (cmp_lt) begin
					hv_q <= rd_a;
				end else begin
					hi_q <= hi_q - AW'(1);
				end
			end
			ST_SW_HI: begin
				lo_q <= pvt_q + AW'(1);
				hi_q <= last_idx;
			end
			ST_RV_WHI: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			ST_OUT_PUT: begin
				if (out_free) begin
					k_q <= k_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_value_q  <= rd_a;
			out_last_q   <= k_last;
			has_next_q   <= nxt_q;
			overflowed_q <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign has_next   = has_next_q;
	assign overflowed = overflowed_q;

	`ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= FULL_CNT, "element count beyond capacity")
	`ASSERT_NEXT(a_close_leaves_load, in_acc && elem_last, state_q != ST_LOAD, "closing ignored")
	`ASSERT_NOW(a_hi_above_pivot, state_q == ST_HI_CMP, hi_q > pvt_q, "search passed pivot")
	`ASSERT_NOW(a_rev_order, state_q == ST_RV_WLO, lo_q < hi_q, "reversal indexes crossed")
	`ASSERT_NOW(a_emit_index, state_q == ST_OUT_PUT, k_q <= last_idx, "index beyond run")

endmodule
